[rtl/bbpd_pkg.sv]
package bbpd_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned InkW      = 27;
  localparam int unsigned RowsW     = 15;
  localparam int unsigned VerdictW  = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam int unsigned WidthW    = 14;
  localparam int unsigned HeightW   = 15;
  localparam int unsigned SideW     = 16;
  localparam int unsigned IptW      = 10;
  localparam int unsigned RunW      = 8;

  localparam int unsigned DefMaxWidth  = 8192;
  localparam int unsigned DefMaxHeight = 16384;

  localparam int unsigned InkDivisor    = 1000;
  localparam int unsigned RecipW        = 32;
  localparam int unsigned InkRecipShift = 41;
  // floor(n / 1000) == (n * InkRecip) >> InkRecipShift for n up to 2**32
  localparam logic [RecipW-1:0] InkRecip = 32'd2199023256;

  localparam logic [InkW-1:0]  InkSat  = {InkW{1'b1}};
  localparam logic [RowsW-1:0] RowsSat = {RowsW{1'b1}};
  localparam logic [RunW-1:0]  RunSat  = {RunW{1'b1}};

  localparam logic [WidthW-1:0]  RstImageWidth     = 14'd8192;
  localparam logic [HeightW-1:0] RstImageHeight    = 15'd16384;
  localparam logic [SideW-1:0]   RstSideNumber     = 16'd1;
  localparam logic [PixW-1:0]    RstBlankThreshold = 8'd245;
  localparam logic [IptW-1:0]    RstInkPerThousand = 10'd6;
  localparam logic [PixW-1:0]    RstStrokeThresh   = 8'd180;
  localparam logic [RunW-1:0]    RstStrokeMinRun   = 8'd4;
  localparam logic [RowsW-1:0]   RstStrokeMinRows  = 15'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth,
    CfgImageHeight,
    CfgSideNumber,
    CfgBlankThreshold,
    CfgInkPerThousand,
    CfgStrokeThreshold,
    CfgStrokeMinRun,
    CfgStrokeMinRows
  } cfg_idx_e;

  typedef enum logic [VerdictW-1:0] {
    VerdictBlank,
    VerdictOdd,
    VerdictInk,
    VerdictStrokes
  } verdict_e;

  typedef struct packed {
    logic [WidthW-1:0]  image_width;
    logic [HeightW-1:0] image_height;
    logic [SideW-1:0]   side_number;
    logic [PixW-1:0]    blank_threshold;
    logic [IptW-1:0]    ink_per_thousand;
    logic [PixW-1:0]    stroke_threshold;
    logic [RunW-1:0]    stroke_min_run;
    logic [RowsW-1:0]   stroke_min_rows;
  } bbpd_cfg_t;

  typedef struct packed {
    logic            busy;
    logic [InkW-1:0] value;
  } bbpd_lim_t;

endpackage

[rtl/bbpd_if.sv]
interface bbpd_pix_if;
  import bbpd_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bbpd_res_if;
  import bbpd_pkg::*;
  logic                valid;
  logic                ready;
  logic                is_blank;
  logic [VerdictW-1:0] verdict;
  logic [InkW-1:0]     ink_count;
  logic [RowsW-1:0]    stroke_rows;
  modport source (output valid, output is_blank, output verdict, output ink_count,
                  output stroke_rows, input ready);
  modport sink   (input valid, input is_blank, input verdict, input ink_count,
                  input stroke_rows, output ready);
endinterface

interface bbpd_cfg_if;
  import bbpd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bbpd_limit.sv]
module bbpd_limit #(
  parameter int unsigned MAX_WIDTH  = bbpd_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = bbpd_pkg::DefMaxHeight
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      w_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     h_i,
  input  logic [bbpd_pkg::IptW-1:0]           ipt_i,
  output bbpd_pkg::bbpd_lim_t                 lim_o
);
  import bbpd_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW = WW + HW;
  localparam int unsigned QW = PW + RecipW;
  localparam int unsigned SW = PW + IptW;

  typedef enum logic [1:0] {LimMul, LimDiv, LimScale, LimIdle} lim_state_e;

  lim_state_e        state_q;
  logic [PW-1:0]     p_q;
  logic [InkW-1:0]   lim_q;

  logic [QW-1:0]     recip_prod;
  logic [SW-1:0]     prod;

  assign recip_prod = QW'(p_q) * QW'(InkRecip);
  assign prod       = SW'(p_q) * SW'(ipt_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LimMul;
      p_q     <= '0;
      lim_q   <= '0;
    end else if (start_i) begin
      state_q <= LimMul;
    end else begin
      case (state_q)
        LimMul: begin
          p_q     <= PW'(w_i) * PW'(h_i);
          state_q <= LimDiv;
        end
        LimDiv: begin
          p_q     <= PW'(recip_prod >> InkRecipShift);
          state_q <= LimScale;
        end
        LimScale: begin
          lim_q   <= (64'(prod) > 64'(InkSat)) ? InkSat : InkW'(prod);
          state_q <= LimIdle;
        end
        default: state_q <= LimIdle;
      endcase
    end
  end

  assign lim_o.busy  = (state_q != LimIdle) || start_i;
  assign lim_o.value = lim_q;

  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> state_q == LimMul)
    else $error("limit unit did not restart");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == LimIdle && !start_i |=> state_q == LimIdle)
    else $error("limit unit left idle without a start");

  a_quot_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == LimScale |->
      p_q <= PW'(64'(MAX_WIDTH) * 64'(MAX_HEIGHT) / 64'(InkDivisor)))
    else $error("area quotient out of range");

endmodule

[rtl/bbpd_scan.sv]
module bbpd_scan #(
  parameter int unsigned MAX_WIDTH  = bbpd_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = bbpd_pkg::DefMaxHeight
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bbpd_pix_if.sink                        pix_i,
  bbpd_res_if.source                      res_o,
  input  bbpd_pkg::bbpd_cfg_t             cfg_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  w_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] h_i,
  input  bbpd_pkg::bbpd_lim_t             lim_i
);
  import bbpd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic            vld_q;
  logic [PixW-1:0] pix_q;

  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [InkW-1:0]  ink_q;
  logic [InkW-1:0]  lim_q;
  logic [RunW-1:0]  run_q;
  logic             rstroke_q;
  logic [RowsW-1:0] srows_q;

  logic             res_vld_q;
  logic             res_blank_q;
  verdict_e         res_verdict_q;
  logic [InkW-1:0]  res_ink_q;
  logic [RowsW-1:0] res_rows_q;

  logic             col_last, row_last, page_end, first, adv;
  logic             dark, stroke_now;
  logic [InkW-1:0]  ink_new, lim_cur;
  logic [RunW-1:0]  run_new;
  logic [RowsW-1:0] srows_new;
  verdict_e         verdict;

  assign col_last = (32'(col_q) + 32'd1) >= 32'(w_i);
  assign row_last = (32'(row_q) + 32'd1) >= 32'(h_i);
  assign page_end = col_last && row_last;
  assign first    = (col_q == '0) && (row_q == '0);
  assign adv      = vld_q && !lim_i.busy && (!page_end || !res_vld_q || res_o.ready);

  assign pix_i.ready = !vld_q || adv;

  assign ink_new = (pix_q < cfg_i.blank_threshold && ink_q != InkSat) ? ink_q + 1'b1 : ink_q;
  assign dark    = pix_q < cfg_i.stroke_threshold;
  assign run_new = !dark ? '0 : (run_q == RunSat ? run_q : run_q + 1'b1);
  assign stroke_now = rstroke_q || (dark && run_new >= cfg_i.stroke_min_run);
  assign srows_new  = (stroke_now && srows_q != RowsSat) ? srows_q + 1'b1 : srows_q;
  assign lim_cur    = first ? lim_i.value : lim_q;

  always_comb begin
    if (cfg_i.side_number[0]) begin
      verdict = VerdictOdd;
    end else if (ink_new > lim_cur) begin
      verdict = VerdictInk;
    end else if (srows_new >= cfg_i.stroke_min_rows) begin
      verdict = VerdictStrokes;
    end else begin
      verdict = VerdictBlank;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pix_i.valid && pix_i.ready) begin
      vld_q <= 1'b1;
    end else if (adv) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      pix_q <= pix_i.pixel;
    end
    if (adv) begin
      lim_q <= lim_cur;
    end
    if (adv && page_end) begin
      res_blank_q   <= verdict == VerdictBlank;
      res_verdict_q <= verdict;
      res_ink_q     <= ink_new;
      res_rows_q    <= srows_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      ink_q     <= '0;
      run_q     <= '0;
      rstroke_q <= 1'b0;
      srows_q   <= '0;
    end else if (adv) begin
      if (page_end) begin
        col_q     <= '0;
        row_q     <= '0;
        ink_q     <= '0;
        run_q     <= '0;
        rstroke_q <= 1'b0;
        srows_q   <= '0;
      end else if (col_last) begin
        col_q     <= '0;
        row_q     <= row_q + 1'b1;
        ink_q     <= ink_new;
        run_q     <= '0;
        rstroke_q <= 1'b0;
        srows_q   <= srows_new;
      end else begin
        col_q     <= col_q + 1'b1;
        ink_q     <= ink_new;
        run_q     <= run_new;
        rstroke_q <= stroke_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv && page_end) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  assign res_o.valid       = res_vld_q;
  assign res_o.is_blank    = res_blank_q;
  assign res_o.verdict     = res_verdict_q;
  assign res_o.ink_count   = res_ink_q;
  assign res_o.stroke_rows = res_rows_q;

  a_page_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && page_end |=> first && ink_q == '0 && srows_q == '0)
    else $error("page counters not cleared after last pixel");

  a_row_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q == '0 |-> run_q == '0 && !rstroke_q)
    else $error("run state carried across a row boundary");

  a_blank_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> res_blank_q == (res_verdict_q == VerdictBlank))
    else $error("blank flag disagrees with verdict");

endmodule

[rtl/blank_back_page_detector_core.sv]
// Blank back page detector.
// pix_i: one 8-bit grey pixel per word, raster order, valid/ready.
// cfg_i: register writes (index, data), always ready; page size and
//   ink_per_thousand writes restart the ink limit unit.
// res_o: one word per page after its last pixel: is_blank, verdict,
//   ink_count, stroke_rows.
// Throughput: one pixel per cycle while the ink limit unit is idle and
//   no page end waits on a stalled result. The last pixel passes the
//   input register, then the counter stage writes the result register.
// The ink limit (w*h/1000)*ink_per_thousand comes from a unit that steps
//   through multiply, divide by 1000 as a reciprocal multiply, and a scale step.
//   While it runs, after reset and after a write that restarts it, pixels
//   are held in the input register.
// A stalled result holds in the result register; the pixel after the last
//   one of a page still enters and its row keeps counting, only the next
//   page end waits for the result to be taken.
// Reset clears all counters and loads default configuration.
module blank_back_page_detector_core #(
  parameter int unsigned MAX_WIDTH  = bbpd_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = bbpd_pkg::DefMaxHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbpd_pix_if.sink    pix_i,
  bbpd_cfg_if.sink    cfg_i,
  bbpd_res_if.source  res_o
);
  import bbpd_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  bbpd_cfg_t       cfg_q;
  bbpd_lim_t       lim;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic            cfg_wr;
  logic            lim_start;
  cfg_idx_e        cfg_idx;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;
  assign cfg_idx     = cfg_idx_e'(cfg_i.index);
  assign lim_start   = cfg_wr && (cfg_idx == CfgImageWidth || cfg_idx == CfgImageHeight ||
                                  cfg_idx == CfgInkPerThousand);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width      <= RstImageWidth;
      cfg_q.image_height     <= RstImageHeight;
      cfg_q.side_number      <= RstSideNumber;
      cfg_q.blank_threshold  <= RstBlankThreshold;
      cfg_q.ink_per_thousand <= RstInkPerThousand;
      cfg_q.stroke_threshold <= RstStrokeThresh;
      cfg_q.stroke_min_run   <= RstStrokeMinRun;
      cfg_q.stroke_min_rows  <= RstStrokeMinRows;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CfgImageWidth:      cfg_q.image_width      <= cfg_i.data[WidthW-1:0];
        CfgImageHeight:     cfg_q.image_height     <= cfg_i.data[HeightW-1:0];
        CfgSideNumber:      cfg_q.side_number      <= cfg_i.data[SideW-1:0];
        CfgBlankThreshold:  cfg_q.blank_threshold  <= cfg_i.data[PixW-1:0];
        CfgInkPerThousand:  cfg_q.ink_per_thousand <= cfg_i.data[IptW-1:0];
        CfgStrokeThreshold: cfg_q.stroke_threshold <= cfg_i.data[PixW-1:0];
        CfgStrokeMinRun:    cfg_q.stroke_min_run   <= cfg_i.data[RunW-1:0];
        CfgStrokeMinRows:   cfg_q.stroke_min_rows  <= cfg_i.data[RowsW-1:0];
        default: ;
      endcase
    end
  end

  // zero size acts as 1, oversize clamps to the maximum
  always_comb begin
    if (cfg_q.image_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_q.image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_q.image_width);
    end
    if (cfg_q.image_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_q.image_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_q.image_height);
    end
  end

  bbpd_limit #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_limit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lim_start),
    .w_i     (w_eff),
    .h_i     (h_eff),
    .ipt_i   (cfg_q.ink_per_thousand),
    .lim_o   (lim)
  );

  bbpd_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i),
    .res_o  (res_o),
    .cfg_i  (cfg_q),
    .w_i    (w_eff),
    .h_i    (h_eff),
    .lim_i  (lim)
  );

endmodule
